// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/rar_pkg.sv -----
package rar_pkg;

   // operation codes on the kind field
   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_MAG,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_NDIV_GO,
      ST_NDIV_WAIT,
      ST_DDIV_GO,
      ST_DDIV_WAIT,
      ST_OUT
   } state_type;

   // status of an iterative unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ----- rtl/rational_arith_reduce.sv -----
// Rational add, subtract, multiply or divide of two signed fractions, with
// the result reduced to lowest terms and a positive denominator. One word is
// taken at a time; req_ready is low until the result is handed to the output
// register, which holds it while the next word is already accepted. A word
// with a zero denominator, or a divide by a zero numerator, returns 0/1 with
// rsp_error set; a zero result returns 0/1. Any other word runs three products
// on one shared multiplier, a binary gcd with a data-dependent number of steps,
// one shift or subtract per cycle, then two exact divisions by the gcd on one
// restoring divider at one bit per cycle.
module rational_arith_reduce #(
   parameter int IN_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic signed [IN_WIDTH-1:0] req_num_a,
   input  logic signed [IN_WIDTH-1:0] req_den_a,
   input  logic signed [IN_WIDTH-1:0] req_num_b,
   input  logic signed [IN_WIDTH-1:0] req_den_b,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [2*IN_WIDTH:0] rsp_res_num,
   output logic [2*IN_WIDTH-2:0]      rsp_res_den,
   output logic                       rsp_error
);

   localparam int DW = 2 * IN_WIDTH;
   localparam int NW = DW + 1;

   rar_pkg::state_type state_ff, state_in;

   logic [1:0]                 kind_ff, kind_in;
   logic signed [IN_WIDTH-1:0] na_ff, na_in;
   logic signed [IN_WIDTH-1:0] da_ff, da_in;
   logic signed [IN_WIDTH-1:0] nb_ff, nb_in;
   logic signed [IN_WIDTH-1:0] db_ff, db_in;
   logic signed [DW-1:0]       p0_ff, p0_in;
   logic signed [DW-1:0]       p1_ff, p1_in;
   logic signed [NW-1:0]       n_ff, n_in;
   logic signed [DW-1:0]       d_ff, d_in;
   logic [DW-1:0]              mn_ff, mn_in;
   logic [DW-1:0]              md_ff, md_in;
   logic                       neg_ff, neg_in;
   logic [DW-1:0]              qn_ff, qn_in;
   logic [DW-1:0]              qd_ff, qd_in;
   logic                       err_ff, err_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [NW-1:0]       rsp_num_ff, rsp_num_in;
   logic [DW-2:0]              rsp_den_ff, rsp_den_in;
   logic                       rsp_err_ff, rsp_err_in;

   logic signed [IN_WIDTH-1:0] mul_a;
   logic signed [IN_WIDTH-1:0] mul_b;
   logic signed [DW-1:0]       mul_p;

   logic                       gcd_start;
   rar_pkg::unit_stat_type     gcd_stat;
   logic [DW-1:0]              gcd_g;

   logic                       div_start;
   logic [DW-1:0]              div_dividend;
   rar_pkg::unit_stat_type     div_stat;
   logic [DW-1:0]              div_quot;

   logic                       in_bad;
   logic                       out_load;

   // shared multiplier for the cross products
   rar_mult #(.WIDTH(IN_WIDTH)) u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   // gcd of the two magnitudes
   rar_gcd #(.WIDTH(DW)) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .op_a   (mn_ff),
      .op_b   (md_ff),
      .stat   (gcd_stat),
      .gcd_ff (gcd_g)
   );

   // shared divider, used once for the numerator and once for the denominator
   rar_div #(.WIDTH(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_g),
      .stat     (div_stat),
      .quot_ff  (div_quot)
   );

   // no value: zero denominator or divide by zero
   assign in_bad = (req_den_a == '0) || (req_den_b == '0) ||
                   ((req_kind == rar_pkg::KIND_DIV) && (req_num_b == '0));

   // sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      na_in        = na_ff;
      da_in        = da_ff;
      nb_in        = nb_ff;
      db_in        = db_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      mn_in        = mn_ff;
      md_in        = md_ff;
      neg_in       = neg_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      err_in       = err_ff;
      req_ready    = 1'b0;
      gcd_start    = 1'b0;
      div_start    = 1'b0;
      div_dividend = mn_ff;
      mul_a        = na_ff;
      mul_b        = db_ff;
      out_load     = 1'b0;
      case (state_ff)
         rar_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in = req_kind;
               na_in   = req_num_a;
               da_in   = req_den_a;
               nb_in   = req_num_b;
               db_in   = req_den_b;
               if (in_bad) begin
                  qn_in    = '0;
                  qd_in    = DW'(1);
                  err_in   = 1'b1;
                  neg_in   = 1'b0;
                  state_in = rar_pkg::ST_OUT;
               end else begin
                  err_in   = 1'b0;
                  state_in = rar_pkg::ST_MUL0;
               end
            end
         end
         // first numerator product
         rar_pkg::ST_MUL0: begin
            mul_a    = na_ff;
            mul_b    = (kind_ff == rar_pkg::KIND_MUL) ? nb_ff : db_ff;
            state_in = rar_pkg::ST_MUL1;
         end
         // second numerator product
         rar_pkg::ST_MUL1: begin
            mul_a    = nb_ff;
            mul_b    = da_ff;
            p0_in    = mul_p;
            state_in = rar_pkg::ST_MUL2;
         end
         // denominator product
         rar_pkg::ST_MUL2: begin
            mul_a    = da_ff;
            mul_b    = (kind_ff == rar_pkg::KIND_DIV) ? nb_ff : db_ff;
            p1_in    = mul_p;
            state_in = rar_pkg::ST_SUM;
         end
         // combine numerator products
         rar_pkg::ST_SUM: begin
            case (kind_ff)
               rar_pkg::KIND_ADD: n_in = NW'(p0_ff) + NW'(p1_ff);
               rar_pkg::KIND_SUB: n_in = NW'(p0_ff) - NW'(p1_ff);
               default:           n_in = NW'(p0_ff);
            endcase
            d_in     = mul_p;
            state_in = rar_pkg::ST_MAG;
         end
         // sign and magnitudes, zero result short cut
         rar_pkg::ST_MAG: begin
            if (n_ff == '0) begin
               qn_in    = '0;
               qd_in    = DW'(1);
               neg_in   = 1'b0;
               state_in = rar_pkg::ST_OUT;
            end else begin
               neg_in   = n_ff[NW-1] ^ d_ff[DW-1];
               mn_in    = n_ff[NW-1] ? DW'(-n_ff) : DW'(n_ff);
               md_in    = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);
               state_in = rar_pkg::ST_GCD_GO;
            end
         end
         rar_pkg::ST_GCD_GO: begin
            gcd_start = 1'b1;
            state_in  = rar_pkg::ST_GCD_WAIT;
         end
         rar_pkg::ST_GCD_WAIT: begin
            if (gcd_stat.done) begin
               state_in = rar_pkg::ST_NDIV_GO;
            end
         end
         rar_pkg::ST_NDIV_GO: begin
            div_start    = 1'b1;
            div_dividend = mn_ff;
            state_in     = rar_pkg::ST_NDIV_WAIT;
         end
         rar_pkg::ST_NDIV_WAIT: begin
            if (div_stat.done) begin
               qn_in    = div_quot;
               state_in = rar_pkg::ST_DDIV_GO;
            end
         end
         rar_pkg::ST_DDIV_GO: begin
            div_start    = 1'b1;
            div_dividend = md_ff;
            state_in     = rar_pkg::ST_DDIV_WAIT;
         end
         rar_pkg::ST_DDIV_WAIT: begin
            if (div_stat.done) begin
               qd_in    = div_quot;
               state_in = rar_pkg::ST_OUT;
            end
         end
         // hand over once the output register is free
         rar_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = rar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rar_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_err_in   = rsp_err_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = neg_ff ? -{1'b0, qn_ff} : {1'b0, qn_ff};
         rsp_den_in   = qd_ff[DW-2:0];
         rsp_err_in   = err_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rar_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      na_ff      <= na_in;
      da_ff      <= da_in;
      nb_ff      <= nb_in;
      db_ff      <= db_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      mn_ff      <= mn_in;
      md_ff      <= md_in;
      neg_ff     <= neg_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      err_ff     <= err_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_error   = rsp_err_ff;

endmodule

// ----- rtl/rar_mult.sv -----
module rar_mult #(
   parameter int WIDTH = 16
) (
   input  logic                       clock,
   input  logic signed [WIDTH-1:0]    op_a,
   input  logic signed [WIDTH-1:0]    op_b,
   output logic signed [2*WIDTH-1:0]  prod_ff
);

   logic signed [2*WIDTH-1:0] prod_in;

   // full-width signed product, registered
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/rar_gcd.sv -----
module rar_gcd #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [WIDTH-1:0]          op_a,
   input  logic [WIDTH-1:0]          op_b,
   output rar_pkg::unit_stat_type    stat,
   output logic [WIDTH-1:0]          gcd_ff
);

   localparam int KW = $clog2(WIDTH);

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [WIDTH-1:0] gcd_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // binary gcd: one shift or one subtract per cycle, common twos counted in k
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      gcd_in  = gcd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == b_ff) begin
            gcd_in  = a_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = KW'(k_ff + 1'b1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand and result registers
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      gcd_ff <= gcd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/rar_div.sv -----
module rar_div #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [WIDTH-1:0]          dividend,
   input  logic [WIDTH-1:0]          divisor,
   output rar_pkg::unit_stat_type    stat,
   output logic [WIDTH-1:0]          quot_ff
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH-1:0] quot_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic             fits;

   // restoring division, one quotient bit per cycle; the quotient register
   // shifts the dividend out at the top and the quotient bits in at the bottom
   assign shifted = {rem_ff, quot_ff[WIDTH-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dsr_in  = divisor;
         quot_in = dividend;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? WIDTH'(shifted - {1'b0, dsr_ff}) : shifted[WIDTH-1:0];
         quot_in = {quot_ff[WIDTH-2:0], fits};
         cnt_in  = CW'(cnt_ff - 1'b1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/rar_checker.sv -----
`include "assert_macros.svh"

module rar_checker #(
   parameter int IN_WIDTH = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [2*IN_WIDTH:0] rsp_res_num,
   input logic [2*IN_WIDTH-2:0]      rsp_res_den,
   input logic                       rsp_error
);

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_res_num) && $stable(rsp_res_den) && $stable(rsp_error))

   // one word at a time: busy right after an accept
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // error words carry 0/1
   `ASSERT_IMPL(a_err_zero_one, clock, reset, rsp_valid && rsp_error, rsp_res_num == '0 && rsp_res_den == 1)

   // zero results are normalized to 0/1
   `ASSERT_IMPL(a_zero_norm, clock, reset, rsp_valid && rsp_res_num == '0, rsp_res_den == 1)

   // denominator is never zero
   `ASSERT_IMPL(a_den_nonzero, clock, reset, rsp_valid, rsp_res_den != '0)

endmodule

bind rational_arith_reduce rar_checker #(.IN_WIDTH(IN_WIDTH)) u_rar_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_res_num (rsp_res_num),
   .rsp_res_den (rsp_res_den),
   .rsp_error   (rsp_error)
);
